### rtl/flv_pkg.sv
// ----------------------------------------------------------------------------
// flv_pkg
// Shared types, character codes and class decode for the float literal
// validator.
// ----------------------------------------------------------------------------
package flv_pkg;

    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [1:0] SC_DIGIT = 2'd0;
    localparam logic [1:0] SC_PLUS  = 2'd1;
    localparam logic [1:0] SC_MINUS = 2'd2;
    localparam logic [1:0] SC_OTHER = 2'd3;

    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_MORE  = 2'd2;

    localparam logic [1:0] SIGN_MAX = 2'd3;
    localparam logic [1:0] SIGN_TWO = 2'd2;

    typedef enum logic [2:0] {
        CL_NONE  = 3'd0,
        CL_DIGIT = 3'd1,
        CL_SIGN  = 3'd2,
        CL_EXP   = 3'd3,
        CL_DOT   = 3'd4,
        CL_OTHER = 3'd5
    } cls_t;

    typedef enum logic [1:0] {
        PEND_NONE      = 2'd0,
        PEND_LEAD_SIGN = 2'd1,
        PEND_LEAD_DOT  = 2'd2,
        PEND_LATE_SIGN = 2'd3
    } pend_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       no_char;
    } item_t;

    typedef struct packed {
        logic       valid_res;
        logic [1:0] sign_class;
    } result_t;

    typedef struct packed {
        logic [1:0] position_phase;
        cls_t       prev_class;
        logic [1:0] sign_count;
        logic       dot_seen;
        logic       exp_seen;
        logic       failed;
        pend_t      pending_rule;
        logic [1:0] first_class;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{
        position_phase: PHASE_START,
        prev_class:     CL_NONE,
        sign_count:     2'd0,
        dot_seen:       1'b0,
        exp_seen:       1'b0,
        failed:         1'b0,
        pending_rule:   PEND_NONE,
        first_class:    SC_DIGIT
    };

    function automatic cls_t classify(input logic [7:0] ch);
        cls_t c;
        if (ch inside {[CH_ZERO:CH_NINE]})
            c = CL_DIGIT;
        else if (ch == CH_PLUS || ch == CH_MINUS)
            c = CL_SIGN;
        else if (ch == CH_LOWER_E || ch == CH_UPPER_E)
            c = CL_EXP;
        else if (ch == CH_POINT)
            c = CL_DOT;
        else
            c = CL_OTHER;
        return c;
    endfunction

endpackage

### rtl/flv_in_stage.sv
// ----------------------------------------------------------------------------
// flv_in_stage
// Input register: captures one word and holds it until the scanner takes it.
// ----------------------------------------------------------------------------
module flv_in_stage
    import flv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] character,
    input  logic       last,
    input  logic       no_char,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t item_reg;
    logic  load;

    assign in_ready = !stage_valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (load)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.character <= character;
            item_reg.last      <= last;
            item_reg.no_char   <= no_char;
        end
    end

    assign item_valid = stage_valid_reg;
    assign item       = item_reg;

endmodule

### rtl/flv_scan.sv
// ----------------------------------------------------------------------------
// flv_scan
// Literal scanner: per-character rule checks, pending lookahead checks and
// the end-of-literal verdict.
// ----------------------------------------------------------------------------
module flv_scan
    import flv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    input  logic    out_busy,
    output logic    advance,
    output logic    res_valid,
    output result_t res
);

    scan_state_t st_reg;
    scan_state_t st_next;
    scan_state_t taken;
    scan_state_t fin_src;
    cls_t        cls;
    logic        ends;

    assign cls       = classify(item.character);
    assign ends      = item.last || item.no_char;
    // hold a word that ends a literal while a result is still waiting downstream
    assign advance   = item_valid && !(ends && out_busy);
    assign res_valid = advance && ends;

    always_comb
    begin
        taken              = st_reg;
        taken.pending_rule = PEND_NONE;

        case (st_reg.pending_rule)
            PEND_LEAD_SIGN:
            begin
                if (cls == CL_EXP || cls == CL_SIGN)
                    taken.failed = 1'b1;
                if (cls == CL_DOT)
                    taken.pending_rule = PEND_LEAD_DOT;
            end
            PEND_LEAD_DOT:
            begin
                if (cls == CL_EXP)
                    taken.failed = 1'b1;
            end
            PEND_LATE_SIGN:
            begin
                if (st_reg.sign_count == SIGN_TWO)
                begin
                    if (cls != CL_DIGIT)
                        taken.failed = 1'b1;
                end
                else if (cls == CL_EXP)
                    taken.failed = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (st_reg.position_phase == PHASE_START)
        begin
            if (cls == CL_DIGIT)
                taken.first_class = SC_DIGIT;
            else if (item.character == CH_PLUS)
                taken.first_class = SC_PLUS;
            else if (item.character == CH_MINUS)
                taken.first_class = SC_MINUS;
            else
                taken.first_class = SC_OTHER;
        end

        case (cls)
            CL_SIGN:
            begin
                if (st_reg.sign_count != SIGN_MAX)
                    taken.sign_count = st_reg.sign_count + 2'd1;
                if (st_reg.sign_count >= SIGN_TWO)
                    taken.failed = 1'b1;
                if (st_reg.position_phase == PHASE_START)
                    taken.pending_rule = PEND_LEAD_SIGN;
                else
                begin
                    if (st_reg.prev_class != CL_EXP)
                        taken.failed = 1'b1;
                    taken.pending_rule = PEND_LATE_SIGN;
                end
            end
            CL_DOT:
            begin
                if (st_reg.dot_seen || st_reg.exp_seen)
                    taken.failed = 1'b1;
                if (st_reg.position_phase != PHASE_START
                    && st_reg.prev_class != CL_SIGN
                    && st_reg.prev_class != CL_DIGIT)
                    taken.failed = 1'b1;
                taken.dot_seen = 1'b1;
            end
            CL_EXP:
            begin
                if (st_reg.exp_seen || st_reg.position_phase == PHASE_START)
                    taken.failed = 1'b1;
                taken.exp_seen = 1'b1;
            end
            CL_OTHER:
                taken.failed = 1'b1;
            default:
            begin
            end
        endcase

        taken.prev_class = cls;
        if (st_reg.position_phase != PHASE_MORE)
            taken.position_phase = st_reg.position_phase + 2'd1;
    end

    // verdict on the state after the last character received
    always_comb
    begin
        fin_src        = item.no_char ? st_reg : taken;
        res.valid_res  = 1'b1;
        res.sign_class = fin_src.first_class;
        if (fin_src.position_phase == PHASE_START)
        begin
            res.valid_res  = 1'b0;
            res.sign_class = SC_OTHER;
        end
        else
        begin
            if (fin_src.failed)
                res.valid_res = 1'b0;
            if (fin_src.prev_class == CL_SIGN || fin_src.prev_class == CL_EXP)
                res.valid_res = 1'b0;
            if (fin_src.position_phase == PHASE_ONE && fin_src.prev_class == CL_DOT)
                res.valid_res = 1'b0;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        if (advance)
            st_next = ends ? SCAN_CLEAR : taken;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= SCAN_CLEAR;
        else
            st_reg <= st_next;
    end

endmodule

### rtl/flv_out_stage.sv
// ----------------------------------------------------------------------------
// flv_out_stage
// Result register: holds one verdict word until the consumer takes it.
// ----------------------------------------------------------------------------
module flv_out_stage
    import flv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  result_t    res,
    output logic       out_busy,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res,
    output logic [1:0] sign_class
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    assign out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign valid_res  = res_reg.valid_res;
    assign sign_class = res_reg.sign_class;

endmodule

### rtl/float_literal_validator_core.sv
// A result word is registered in the result register when its last character leaves the input register.
// Throughput: one character per cycle; the scan state update
// between the input register and the result register sets this rate.
// A pending result stalls the input only when the next word also ends a literal.
// Reset (rst_n low, asynchronous) empties both registers and clears the scan
// state to the start of a literal.
// ----------------------------------------------------------------------------
// float_literal_validator_core
// Decimal float literal syntax checker, one character per word.
// ----------------------------------------------------------------------------
module float_literal_validator_core
    import flv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] character,
    input  logic       last,
    input  logic       no_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res,
    output logic [1:0] sign_class
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    logic    out_busy;
    logic    res_valid;
    result_t res;

    flv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .last       (last),
        .no_char    (no_char),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    flv_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_busy   (out_busy),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    flv_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .out_busy   (out_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .valid_res  (valid_res),
        .sign_class (sign_class)
    );

endmodule

### rtl/flv_checker.sv
// ----------------------------------------------------------------------------
// flv_checker
// Port-level checks for the float literal validator, bound to the top level.
// ----------------------------------------------------------------------------
module flv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       last,
    input logic       no_char,
    input logic       out_valid,
    input logic       out_ready,
    input logic       valid_res,
    input logic [1:0] sign_class
);

    logic [1:0] open_reg;
    logic [1:0] open_next;
    logic       end_in;
    logic       word_out;

    assign end_in   = in_valid && in_ready && (last || no_char);
    assign word_out = out_valid && out_ready;

    // count literals ended at the input but not yet delivered
    always_comb
    begin
        open_next = open_reg;
        if (end_in && !word_out)
            open_next = open_reg + 2'd1;
        else if (word_out && !end_in)
            open_next = open_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 2'd0;
        else
            open_reg <= open_next;
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result word valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(sign_class))
        else $error("stalled result word changed");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 2'd0)
        else $error("result word without an ended literal");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 2'd3)
        else $error("too many literals in flight");

endmodule

bind float_literal_validator_core flv_checker u_flv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last       (last),
    .no_char    (no_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .sign_class (sign_class)
);
